// ===== rtl/assert_macros.svh =====
// assertion helpers, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pme_pkg.sv =====
`default_nettype none

package pme_pkg;

	// depth of the parenthesis sign stack, bottom entry included
	localparam int NEST_DEPTH = 32;
	localparam int LEVEL_W    = $clog2(NEST_DEPTH + 1);
	localparam int DATA_W     = 32;

	// character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// per-cycle command to every stack cell
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} stack_op_t;

endpackage

`default_nettype wire

// ===== rtl/pme_cell.sv =====
`default_nettype none

module pme_cell
	import pme_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire stack_op_t op,
	input  wire logic      init_bit,
	input  wire logic      from_upper,
	input  wire logic      from_lower,
	output logic           bit_out
);

	logic cell_q;

	// clear wins, then push (shift down), then pop (shift up)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= init_bit;
		end else if (op.clear) begin
			cell_q <= init_bit;
		end else if (op.push) begin
			cell_q <= from_upper;
		end else if (op.pop) begin
			cell_q <= from_lower;
		end
	end

	assign bit_out = cell_q;

endmodule

`default_nettype wire

// ===== rtl/pme_sign_stack.sv =====
`default_nettype none

`include "assert_macros.svh"

module pme_sign_stack
	import pme_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_req,
	input  wire logic pop_req,
	input  wire logic clear,
	input  wire logic push_bit,
	output logic      top_sign,
	output logic      err_now
);

	logic [LEVEL_W-1:0]    level_q;
	logic                  err_q;
	logic [NEST_DEPTH-1:0] stack_bits;
	logic                  full;
	logic                  at_bottom;
	logic                  push_ok;
	logic                  pop_ok;
	stack_op_t             op;

	assign full      = (level_q == LEVEL_W'(NEST_DEPTH));
	assign at_bottom = (level_q == LEVEL_W'(1));
	assign push_ok   = push_req && !full;
	assign pop_ok    = pop_req && !at_bottom;
	assign err_now   = err_q || (push_req && full) || (pop_req && at_bottom);

	assign op.clear = clear;
	assign op.push  = push_ok;
	assign op.pop   = pop_ok;

	// cell 0 is the top of stack
	for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_cell
		logic upper;
		logic lower;
		if (i == 0) begin : g_top
			assign upper = push_bit;
		end else begin : g_mid
			assign upper = stack_bits[i-1];
		end
		if (i == NEST_DEPTH - 1) begin : g_end
			assign lower = 1'b0;
		end else begin : g_inner
			assign lower = stack_bits[i+1];
		end
		pme_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.init_bit   ((i == 0) ? 1'b1 : 1'b0),
			.from_upper (upper),
			.from_lower (lower),
			.bit_out    (stack_bits[i])
		);
	end

	assign top_sign = stack_bits[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_W'(1);
			err_q   <= 1'b0;
		end else if (clear) begin
			level_q <= LEVEL_W'(1);
			err_q   <= 1'b0;
		end else begin
			err_q <= err_now;
			if (push_ok) begin
				level_q <= level_q + LEVEL_W'(1);
			end else if (pop_ok) begin
				level_q <= level_q - LEVEL_W'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_level_nonzero, clk, arst_n, level_q != '0)
	`ASSERT_ALWAYS(a_level_bound, clk, arst_n, level_q <= LEVEL_W'(NEST_DEPTH))
	`ASSERT_NEXT(a_clear_restores, clk, arst_n, clear, at_bottom && stack_bits[0] && !err_q)
	`ASSERT_NEXT(a_refused_push_flags, clk, arst_n, push_req && full && !clear, err_q)

endmodule

`default_nettype wire

// ===== rtl/plus_minus_expression_evaluator.sv =====
`default_nettype none

// Evaluates an expression of decimal integers, '+', '-', parentheses and
// spaces, one character per input transaction, with last_char marking the
// final character. Any other character counts as a digit. A new character
// is taken every cycle while in_stall is low; the only loop is the update
// of the number register (times ten plus digit) and running total. When the
// last character is taken the evaluator returns to its reset state at once,
// and the result transaction (value wrapped to 32 bits, plus nest_error)
// passes through a two-stage output pipe that holds
// under out_stall. The sign stack is a row of 32 one-bit cells that shift
// on '(' and ')'; a push onto a full stack or a pop of the bottom entry is
// refused and sets nest_error for that expression. in_stall rises only
// while a finished result is waiting and the output pipe is full.
module plus_minus_expression_evaluator
	import pme_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         char_code,
	input  wire logic               last_char,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [DATA_W-1:0] result_value,
	output logic                    nest_error
);

	// evaluator state
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] num_q;
	logic              sign_q;

	// output pipe
	logic              valid_s1;
	logic [DATA_W-1:0] total_s1;
	logic [DATA_W-1:0] num_s1;
	logic              neg_s1;
	logic              err_s1;
	logic              valid_s2;
	logic [DATA_W-1:0] result_s2;
	logic              err_s2;

	logic              accept;
	logic              adv_s2;
	logic              is_plus;
	logic              is_minus;
	logic              is_op;
	logic              is_lpar;
	logic              is_rpar;
	logic              is_digit;
	logic              top_sign;
	logic              err_now;
	logic [DATA_W-1:0] signed_num;
	logic [DATA_W-1:0] digit_val;
	logic [DATA_W-1:0] total_nxt;
	logic [DATA_W-1:0] num_nxt;
	logic              sign_nxt;

	// character decode
	assign is_plus  = (char_code == CH_PLUS);
	assign is_minus = (char_code == CH_MINUS);
	assign is_op    = is_plus || is_minus;
	assign is_lpar  = (char_code == CH_LPAR);
	assign is_rpar  = (char_code == CH_RPAR);
	assign is_digit = !is_op && !is_lpar && !is_rpar && (char_code != CH_SPACE);

	// handshake: the pipe moves when stage 2 is free or being drained
	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign accept   = in_valid && !in_stall;

	pme_sign_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (accept && is_lpar),
		.pop_req  (accept && is_rpar),
		.clear    (accept && last_char),
		.push_bit (sign_q),
		.top_sign (top_sign),
		.err_now  (err_now)
	);

	// next evaluator state for the character on the port
	assign signed_num = sign_q ? num_q : (DATA_W'(0) - num_q);
	assign digit_val  = {{(DATA_W-8){1'b0}}, char_code} - {{(DATA_W-8){1'b0}}, CH_ZERO};

	always_comb begin
		total_nxt = total_q;
		num_nxt   = num_q;
		sign_nxt  = sign_q;
		if (is_op) begin
			total_nxt = total_q + signed_num;
			// sign inside the current bracket level, flipped for minus
			sign_nxt  = (top_sign == is_plus);
			num_nxt   = '0;
		end else if (is_digit) begin
			// times ten as two shifts and an add
			num_nxt = (num_q << 3) + (num_q << 1) + digit_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			num_q   <= '0;
			sign_q  <= 1'b1;
		end else if (accept) begin
			if (last_char) begin
				total_q <= '0;
				num_q   <= '0;
				sign_q  <= 1'b1;
			end else begin
				total_q <= total_nxt;
				num_q   <= num_nxt;
				sign_q  <= sign_nxt;
			end
		end
	end

	// stage 1: capture the closing state of the expression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && last_char) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_char) begin
			total_s1 <= total_nxt;
			num_s1   <= num_nxt;
			neg_s1   <= !sign_nxt;
			err_s1   <= err_now;
		end
	end

	// stage 2: fold in the pending number with its sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= neg_s1 ? (total_s1 - num_s1) : (total_s1 + num_s1);
			err_s2    <= err_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign result_value = signed'(result_s2);
	assign nest_error   = err_s2;

endmodule

`default_nettype wire

// ===== tb/sv/tb_plus_minus_expression_evaluator.sv =====
`default_nettype none

module tb_plus_minus_expression_evaluator;
	import pme_pkg::*;

	// run shape
	localparam int N_RANDOM    = 1550;   // random input transactions
	localparam int PHASE_LEN   = 200;    // transactions per idling phase
	localparam int TAIL_CYCLES = 16;     // output pipe is two deep, wait a few more
	localparam int CYCLE_LIMIT = 200000; // far above the slowest legal run
	localparam int SHOW_FAULTS = 10;

	// idling phases, cycled through as transactions go out
	typedef enum logic [1:0] {
		PH_FREE,
		PH_SENDER_IDLE,
		PH_RECEIVER_STALL,
		PH_BOTH
	} idle_phase_t;

	// one character transaction, with an optional typed-in expectation
	typedef struct packed {
		logic [7:0]        ch;
		logic              last;
		logic              typed;
		logic [DATA_W-1:0] val;
		logic              err;
	} char_item_t;

	// one evaluated expression
	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              err;
	} calc_result_t;

	// directed expressions; typed expectations only where obvious
	localparam int N_DIRECTED = 24;
	localparam char_item_t DIRECTED_ROWS [N_DIRECTED] = '{
		// empty expression straight after reset
		'{CH_SPACE, 1'b1, 1'b1, 32'd0, 1'b0},
		// lone close bracket pops the bottom entry: refused
		'{CH_RPAR, 1'b1, 1'b1, 32'd0, 1'b1},
		// highest code counts as digit 255 - 48
		'{8'hFF, 1'b1, 1'b1, 32'd207, 1'b0},
		// code zero counts as digit -48
		'{8'h00, 1'b1, 1'b1, 32'hFFFF_FFD0, 1'b0},
		// bare minus
		'{CH_MINUS, 1'b1, 1'b1, 32'd0, 1'b0},
		// 1-(2-3)
		'{CH_ZERO + 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_MINUS, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_LPAR, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_ZERO + 8'd2, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_MINUS, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_ZERO + 8'd3, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_RPAR, 1'b1, 1'b0, 32'd0, 1'b0},
		// -(5 with the bracket left open: final number takes the inner sign
		'{CH_MINUS, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_LPAR, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_ZERO + 8'd5, 1'b1, 1'b0, 32'd0, 1'b0},
		// 12+ 3
		'{CH_ZERO + 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_ZERO + 8'd2, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_PLUS, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_SPACE, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_ZERO + 8'd3, 1'b1, 1'b0, 32'd0, 1'b0},
		// ())9: balanced pair, then underflow mid expression
		'{CH_LPAR, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_RPAR, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_RPAR, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CH_ZERO + 8'd9, 1'b1, 1'b0, 32'd0, 1'b0}
	};

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic [7:0]               char_code  = 8'd0;
	logic                     last_char  = 1'b0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic signed [DATA_W-1:0] result_value;
	logic                     nest_error;

	plus_minus_expression_evaluator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.last_char    (last_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.nest_error   (nest_error)
	);

	// 12 unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// evaluator model: running total, pending number, sign and the
	// bracket sign stack, all at the block's widths
	// ---------------------------------------------------------------
	logic [DATA_W-1:0]  total_acc;
	logic [DATA_W-1:0]  number_acc;
	logic               sign_plus;
	logic               sign_stack [NEST_DEPTH];
	int unsigned        stack_level;
	logic               nest_fault;

	task automatic clear_evaluator();
		total_acc   = '0;
		number_acc  = '0;
		sign_plus   = 1'b1;
		for (int i = 0; i < NEST_DEPTH; i++)
			sign_stack[i] = 1'b0;
		sign_stack[0] = 1'b1;
		stack_level   = 1;
		nest_fault    = 1'b0;
	endtask

	// number with the current sign applied, wrapping at 32 bits
	function automatic logic [DATA_W-1:0] signed_number();
		return sign_plus ? number_acc : DATA_W'(0) - number_acc;
	endfunction

	// advance the model by one character; done marks a finished expression
	task automatic evaluate_char(input logic [7:0] ch, input logic last,
			output logic done, output calc_result_t res);
		case (ch)
			CH_PLUS, CH_MINUS: begin
				total_acc  = total_acc + signed_number();
				// new sign is the enclosing sign, flipped for minus
				sign_plus  = (sign_stack[stack_level - 1] == (ch == CH_PLUS));
				number_acc = '0;
			end
			CH_LPAR: begin
				if (stack_level < NEST_DEPTH) begin
					sign_stack[stack_level] = sign_plus;
					stack_level++;
				end else begin
					nest_fault = 1'b1;
				end
			end
			CH_RPAR: begin
				if (stack_level > 1)
					stack_level--;
				else
					nest_fault = 1'b1;
			end
			CH_SPACE: ;
			// anything else is a digit, even outside '0'..'9'
			default: number_acc = number_acc * DATA_W'(10) + DATA_W'(ch) - DATA_W'(CH_ZERO);
		endcase
		done = last;
		res  = '{val: total_acc + signed_number(), err: nest_fault};
		if (last)
			clear_evaluator();
	endtask

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------
	char_item_t  char_q [$];   // transactions still to send
	logic [7:0]  expr_buf [$]; // expression under construction
	int          random_count = 0;

	task automatic emit(input logic [7:0] ch);
		expr_buf.push_back(ch);
	endtask

	task automatic maybe_space();
		if ($urandom_range(3) == 0)
			emit(CH_SPACE);
	endtask

	task automatic emit_sign();
		emit($urandom_range(1) ? CH_PLUS : CH_MINUS);
	endtask

	// mostly short numbers, now and then long enough to wrap
	task automatic emit_number();
		int n_digits;
		n_digits = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
		repeat (n_digits)
			emit(CH_ZERO + 8'($urandom_range(9)));
	endtask

	// move the finished expression into the send queue, marking its end
	task automatic flush_expr();
		char_item_t item;
		for (int i = 0; i < expr_buf.size(); i++) begin
			item      = '0;
			item.ch   = expr_buf[i];
			item.last = (i == expr_buf.size() - 1);
			char_q.push_back(item);
		end
		random_count += expr_buf.size();
		expr_buf.delete();
	endtask

	// sums of terms with nested brackets, sometimes left unclosed
	task automatic gen_well_formed();
		int n_terms;
		int depth;
		int n_open;
		int n_close;
		n_terms = $urandom_range(1, 6);
		depth   = 0;
		if ($urandom_range(3) == 0)
			emit(CH_MINUS);
		for (int t = 0; t < n_terms; t++) begin
			if (t != 0) begin
				maybe_space();
				emit_sign();
				maybe_space();
			end
			n_open = (depth < 5) ? $urandom_range(2) : 0;
			repeat (n_open) begin
				emit(CH_LPAR);
				depth++;
				if ($urandom_range(3) == 0)
					emit(CH_MINUS);
			end
			emit_number();
			n_close = $urandom_range(depth);
			repeat (n_close) begin
				emit(CH_RPAR);
				depth--;
			end
		end
		if ($urandom_range(4) != 0)
			repeat (depth) emit(CH_RPAR);
		flush_expr();
	endtask

	// nesting around the stack depth, so pushes hit a full stack and
	// the surplus closes run into the bottom entry
	task automatic gen_deep();
		int n_open;
		n_open = $urandom_range(NEST_DEPTH - 3, NEST_DEPTH + 3);
		repeat (n_open) begin
			emit_sign();
			emit(CH_LPAR);
		end
		emit_number();
		repeat ($urandom_range(n_open + 2)) emit(CH_RPAR);
		if ($urandom_range(1)) begin
			emit_sign();
			emit_number();
		end
		flush_expr();
	endtask

	// random bytes mixed with the legal tokens
	task automatic gen_noise();
		repeat ($urandom_range(1, 16)) begin
			if ($urandom_range(1)) begin
				emit(8'($urandom_range(255)));
			end else begin
				case ($urandom_range(5))
					0: emit(CH_PLUS);
					1: emit(CH_MINUS);
					2: emit(CH_LPAR);
					3: emit(CH_RPAR);
					4: emit(CH_SPACE);
					default: emit(CH_ZERO + 8'($urandom_range(9)));
				endcase
			end
		end
		flush_expr();
	endtask

	// ---------------------------------------------------------------
	// idling control
	// ---------------------------------------------------------------
	int          sent_count = 0;
	idle_phase_t idle_phase;

	assign idle_phase = idle_phase_t'((sent_count / PHASE_LEN) % 4);

	function automatic logic roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic sender_idles();
		case (idle_phase)
			PH_SENDER_IDLE: return roll(61);
			PH_BOTH:        return roll(19);
			default:        return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stalls();
		case (idle_phase)
			PH_RECEIVER_STALL: return roll(61);
			PH_BOTH:           return roll(19);
			default:           return 1'b0;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// driving: everything changes on the falling edge
	// ---------------------------------------------------------------
	logic       feeding  = 1'b0;
	logic       in_taken = 1'b0; // set at the rising edge that took a transaction
	char_item_t cur_item = '0;   // transaction currently on the input port

	always @(negedge clk) begin
		if (feeding) begin
			// a new transaction only once the old one has gone
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (char_q.size() != 0 && !sender_idles()) begin
					cur_item = char_q.pop_front();
					in_valid  <= 1'b1;
					char_code <= cur_item.ch;
					last_char <= cur_item.last;
					sent_count++;
				end else begin
					// junk on the idle bus must be ignored
					in_valid  <= 1'b0;
					char_code <= 8'($urandom_range(255));
					last_char <= 1'($urandom_range(1));
				end
			end
			out_stall <= receiver_stalls();
		end
	end

	// ---------------------------------------------------------------
	// checking: both channels sampled on the rising edge
	// ---------------------------------------------------------------
	calc_result_t awaited_q [$]; // results still owed by the block
	int           fault_count = 0;

	task automatic report_fault(input string what, input calc_result_t want);
		fault_count++;
		if (fault_count <= SHOW_FAULTS)
			$display("mismatch (%s): expected value %0d error %0b, got value %0d error %0b",
				what, $signed(want.val), want.err, result_value, nest_error);
	endtask

	always @(posedge clk) begin : check_blk
		logic         done;
		calc_result_t calc;
		calc_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				evaluate_char(cur_item.ch, cur_item.last, done, calc);
				if (done) begin
					// typed rows carry their own expectation
					if (cur_item.typed)
						calc = '{val: cur_item.val, err: cur_item.err};
					awaited_q.push_back(calc);
				end
			end
			if (out_valid && !out_stall) begin
				if (awaited_q.size() == 0) begin
					report_fault("unexpected result", '0);
				end else begin
					want = awaited_q.pop_front();
					if (result_value !== want.val)
						report_fault("result_value", want);
					else if (nest_error !== want.err)
						report_fault("nest_error", want);
				end
			end
		end
	end

	// watchdog
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_plus_minus_expression_evaluator failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence: build stimulus, reset, run, drain
	// ---------------------------------------------------------------
	initial begin
		int kind;
		clear_evaluator();
		for (int i = 0; i < N_DIRECTED; i++)
			char_q.push_back(DIRECTED_ROWS[i]);
		// mostly well-formed expressions, some deep nesting, some noise
		while (random_count < N_RANDOM) begin
			kind = $urandom_range(99);
			if (kind < 70)
				gen_well_formed();
			else if (kind < 78)
				gen_deep();
			else
				gen_noise();
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n  = 1'b1;
		feeding = 1'b1;

		// every transaction sent and taken
		while (char_q.size() != 0 || in_valid)
			@(posedge clk);
		// every owed result received
		while (awaited_q.size() != 0)
			@(posedge clk);
		// room for anything spurious still in the output pipe
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("tb_plus_minus_expression_evaluator passed");
		else
			$display("tb_plus_minus_expression_evaluator failed");
		$finish;
	end

endmodule

`default_nettype wire
